FILE: sv/tsc_pkg.sv
// tsc_pkg: shared types and constants of the token scanner
// character codes, token kinds, scan modes and the result record
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package tsc_pkg;

    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_EQUAL  = 8'h3D;
    localparam logic [7:0] CH_LESS   = 8'h3C;
    localparam logic [7:0] CH_GREATER = 8'h3E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0A;

    localparam logic [4:0] KIND_LPAREN  = 5'd0;
    localparam logic [4:0] KIND_RPAREN  = 5'd1;
    localparam logic [4:0] KIND_LBRACE  = 5'd2;
    localparam logic [4:0] KIND_RBRACE  = 5'd3;
    localparam logic [4:0] KIND_COMMA   = 5'd4;
    localparam logic [4:0] KIND_DOT     = 5'd5;
    localparam logic [4:0] KIND_MINUS   = 5'd6;
    localparam logic [4:0] KIND_PLUS    = 5'd7;
    localparam logic [4:0] KIND_SEMI    = 5'd8;
    localparam logic [4:0] KIND_STAR    = 5'd9;
    localparam logic [4:0] KIND_BANG    = 5'd10;
    localparam logic [4:0] KIND_EQUAL   = 5'd12;
    localparam logic [4:0] KIND_LESS    = 5'd14;
    localparam logic [4:0] KIND_GREATER = 5'd16;
    localparam logic [4:0] KIND_SLASH   = 5'd18;
    localparam logic [4:0] KIND_STRING  = 5'd19;
    localparam logic [4:0] KIND_EOF     = 5'd20;
    localparam logic [4:0] KIND_UNEXPECTED   = 5'd21;
    localparam logic [4:0] KIND_UNTERMINATED = 5'd22;

    localparam logic [15:0] LINE_FIRST = 16'd1;
    localparam logic [15:0] LINE_MAX   = 16'hFFFF;

    typedef enum logic [7:0] {
        MODE_NORMAL  = 8'b0000_0001,
        MODE_BANG    = 8'b0000_0010,
        MODE_EQUAL   = 8'b0000_0100,
        MODE_LESS    = 8'b0000_1000,
        MODE_GREATER = 8'b0001_0000,
        MODE_SLASH   = 8'b0010_0000,
        MODE_COMMENT = 8'b0100_0000,
        MODE_STRING  = 8'b1000_0000
    } t_mode;

    typedef struct packed {
        logic [4:0]  kind;
        logic [15:0] start;
        logic [15:0] length;
        logic [15:0] line;
        logic        last;
    } t_result;

    typedef struct packed {
        logic    v0;
        logic    v1;
        t_result r0;
        t_result r1;
    } t_scan_out;

endpackage

`default_nettype wire

FILE: sv/tsc_scan.sv
// tsc_scan: scanner state and the combinational step for one request
// gives up to two result records and updates mode, position, token start and line
// depends on tsc_pkg
`timescale 1ns / 1ps
`default_nettype none

module tsc_scan #(
    parameter int POS_WIDTH = 16
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_adv,
    input  wire  [7:0]          i_byte,
    input  wire                 i_end,
    output tsc_pkg::t_scan_out  o_scan
);
    import tsc_pkg::*;

    localparam logic [POS_WIDTH-1:0] POS_MAX = {POS_WIDTH{1'b1}};

    t_mode                r_mode, n_mode;
    logic [POS_WIDTH-1:0] r_pos, n_pos;
    logic [POS_WIDTH-1:0] r_begin, n_begin;
    logic [15:0]          r_line, n_line;

    logic [POS_WIDTH-1:0] cur, tb, tb_inc;
    logic [31:0]          cur32, tb32, diff32;
    logic [15:0]          cur16, tb16, tb_inc16, line_inc;

    // normal-mode scan of the current byte
    logic       sn_emit, sn_set_begin, sn_line;
    logic [4:0] sn_kind;
    t_mode      sn_mode;

    logic       v0, v1;
    t_result    r0, r1;
    logic [4:0] opk;

    always_comb begin
        sn_emit      = 1'b0;
        sn_set_begin = 1'b1;
        sn_line      = 1'b0;
        sn_kind      = KIND_UNEXPECTED;
        sn_mode      = MODE_NORMAL;
        case (i_byte)
            CH_LPAREN:  begin sn_emit = 1'b1; sn_set_begin = 1'b0; sn_kind = KIND_LPAREN; end
            CH_RPAREN:  begin sn_emit = 1'b1; sn_set_begin = 1'b0; sn_kind = KIND_RPAREN; end
            CH_LBRACE:  begin sn_emit = 1'b1; sn_set_begin = 1'b0; sn_kind = KIND_LBRACE; end
            CH_RBRACE:  begin sn_emit = 1'b1; sn_set_begin = 1'b0; sn_kind = KIND_RBRACE; end
            CH_COMMA:   begin sn_emit = 1'b1; sn_set_begin = 1'b0; sn_kind = KIND_COMMA; end
            CH_DOT:     begin sn_emit = 1'b1; sn_set_begin = 1'b0; sn_kind = KIND_DOT; end
            CH_MINUS:   begin sn_emit = 1'b1; sn_set_begin = 1'b0; sn_kind = KIND_MINUS; end
            CH_PLUS:    begin sn_emit = 1'b1; sn_set_begin = 1'b0; sn_kind = KIND_PLUS; end
            CH_SEMI:    begin sn_emit = 1'b1; sn_set_begin = 1'b0; sn_kind = KIND_SEMI; end
            CH_STAR:    begin sn_emit = 1'b1; sn_set_begin = 1'b0; sn_kind = KIND_STAR; end
            CH_BANG:    sn_mode = MODE_BANG;
            CH_EQUAL:   sn_mode = MODE_EQUAL;
            CH_LESS:    sn_mode = MODE_LESS;
            CH_GREATER: sn_mode = MODE_GREATER;
            CH_SLASH:   sn_mode = MODE_SLASH;
            CH_QUOTE:   sn_mode = MODE_STRING;
            CH_SPACE, CH_CR, CH_TAB: sn_mode = MODE_NORMAL;
            CH_NL:      sn_line = 1'b1;
            default:    sn_emit = 1'b1;
        endcase
    end

    always_comb begin
        cur      = r_pos;
        tb       = (r_begin > r_pos) ? r_pos : r_begin;
        tb_inc   = (tb == POS_MAX) ? POS_MAX : tb + 1'b1;
        cur32    = 32'(cur);
        tb32     = 32'(tb);
        diff32   = cur32 - tb32;
        cur16    = cur32[15:0];
        tb16     = tb32[15:0];
        tb_inc16 = 16'(32'(tb_inc));
        line_inc = (r_line != LINE_MAX) ? r_line + 16'd1 : r_line;

        case (r_mode)
            MODE_BANG:    opk = KIND_BANG;
            MODE_EQUAL:   opk = KIND_EQUAL;
            MODE_LESS:    opk = KIND_LESS;
            MODE_GREATER: opk = KIND_GREATER;
            default:      opk = KIND_SLASH;
        endcase

        n_mode  = r_mode;
        n_pos   = (cur == POS_MAX) ? POS_MAX : cur + 1'b1;
        n_begin = tb;
        n_line  = r_line;
        v0      = 1'b0;
        v1      = 1'b0;
        r0      = '{kind: KIND_EOF, start: cur16, length: 16'd0, line: r_line, last: 1'b0};
        r1      = r0;

        if (i_end) begin
            case (r_mode)
                MODE_BANG, MODE_EQUAL, MODE_LESS, MODE_GREATER, MODE_SLASH: begin
                    v0 = 1'b1;
                    r0.kind = opk;
                    r0.start = tb16;
                    r0.length = 16'd1;
                end
                MODE_STRING: begin
                    v0 = 1'b1;
                    r0.kind = KIND_UNTERMINATED;
                    r0.start = tb16;
                    r0.length = diff32[15:0];
                end
                default: v0 = 1'b0;
            endcase
            // eof follows in the next free slot
            if (v0) begin
                v1 = 1'b1;
            end else begin
                v0 = 1'b1;
            end
            n_mode  = MODE_NORMAL;
            n_pos   = '0;
            n_begin = '0;
            n_line  = LINE_FIRST;
        end else begin
            case (r_mode)
                MODE_BANG, MODE_EQUAL, MODE_LESS, MODE_GREATER, MODE_SLASH: begin
                    if (r_mode == MODE_SLASH && i_byte == CH_SLASH) begin
                        n_mode = MODE_COMMENT;
                    end else if (r_mode != MODE_SLASH && i_byte == CH_EQUAL) begin
                        n_mode = MODE_NORMAL;
                        v0 = 1'b1;
                        r0.kind = opk + 5'd1;
                        r0.start = tb16;
                        r0.length = 16'(diff32 + 32'd1);
                    end else begin
                        v0 = 1'b1;
                        r0.kind = opk;
                        r0.start = tb16;
                        r0.length = 16'd1;
                        n_mode = sn_mode;
                        if (sn_set_begin) n_begin = cur;
                        if (sn_line) n_line = line_inc;
                        v1 = sn_emit;
                        r1.kind = sn_kind;
                        r1.start = cur16;
                        r1.length = 16'd1;
                    end
                end
                MODE_COMMENT: begin
                    if (i_byte == CH_NL) begin
                        n_mode = MODE_NORMAL;
                        n_begin = cur;
                        n_line = line_inc;
                    end
                end
                MODE_STRING: begin
                    if (i_byte == CH_QUOTE) begin
                        n_mode = MODE_NORMAL;
                        v0 = 1'b1;
                        r0.kind = KIND_STRING;
                        r0.start = tb_inc16;
                        r0.length = (cur > tb) ? 16'(diff32 - 32'd1) : 16'd0;
                    end else if (i_byte == CH_NL) begin
                        n_line = line_inc;
                    end
                end
                default: begin
                    n_mode = sn_mode;
                    if (sn_set_begin) n_begin = cur;
                    if (sn_line) n_line = line_inc;
                    v0 = sn_emit;
                    r0.kind = sn_kind;
                    r0.start = cur16;
                    r0.length = 16'd1;
                end
            endcase
        end

        r0.last = v0 && !v1;
        r1.last = v1;
        o_scan  = '{v0: v0, v1: v1, r0: r0, r1: r1};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_NORMAL;
            r_pos   <= '0;
            r_begin <= '0;
            r_line  <= LINE_FIRST;
        end else if (i_adv) begin
            r_mode  <= n_mode;
            r_pos   <= n_pos;
            r_begin <= n_begin;
            r_line  <= n_line;
        end
    end

    a_second_needs_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_scan.v1 |-> (o_scan.v0 && !o_scan.r0.last))
        else $error("second result without a first one");

    a_end_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && i_end) |=> (r_pos == '0 && r_line == LINE_FIRST && r_mode == MODE_NORMAL))
        else $error("state not restarted after end of source");

    a_line_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_line != 16'd0))
        else $error("line count wrapped to zero");

endmodule

`default_nettype wire

FILE: sv/tsc_result_q.sv
// tsc_result_q: two-slot result buffer that drains one record per cycle while i_pop is high
// loads the records of one request at once and presents them in order
// depends on tsc_pkg
`timescale 1ns / 1ps
`default_nettype none

module tsc_result_q (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_load,
    input  wire tsc_pkg::t_scan_out i_scan,
    input  wire                     i_pop,
    output logic                    o_free,
    output logic                    o_valid,
    output tsc_pkg::t_result        o_result
);
    import tsc_pkg::*;

    t_result    r_slot0, r_slot1;
    logic [1:0] r_cnt;
    logic       r_head;

    assign o_valid  = (r_cnt != 2'd0);
    assign o_free   = (r_cnt == 2'd0) || (r_cnt == 2'd1 && i_pop);
    assign o_result = r_head ? r_slot1 : r_slot0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= 2'd0;
            r_head <= 1'b0;
        end else if (i_load && (i_scan.v0 || i_scan.v1)) begin
            r_cnt  <= {1'b0, i_scan.v0} + {1'b0, i_scan.v1};
            r_head <= 1'b0;
        end else if (i_pop && o_valid) begin
            r_cnt  <= r_cnt - 2'd1;
            r_head <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && (i_scan.v0 || i_scan.v1)) begin
            r_slot0 <= i_scan.r0;
            r_slot1 <= i_scan.r1;
        end
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != 2'd3) && !(r_cnt == 2'd2 && r_head))
        else $error("result buffer count or head out of range");

    a_pair_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2 && i_pop) |=> (r_cnt == 2'd1 && r_head && o_result.last))
        else $error("second record not presented as last");

endmodule

`default_nettype wire

FILE: sv/token_scanner.sv
// token_scanner: streaming scanner for a small scripting language
// slave side takes one source byte per request (tlast = end of source),
// master side gives token records (tuser = kind, tlast = last record of a request)
// a request accepted on the slave side reaches the input register, is scanned there
// and its records are registered in the result buffer that feeds the master side
// throughput: one request per cycle while each gives at most one record and the master
// side does not stall; a request that gives two records (operator or slash followed by
// another token, or a pending token flushed before eof) fills both slots of the two-slot
// result buffer, whose single record port presents them in order
// requests that give no record (blanks, comment text, string bodies) pass at one per cycle
// a stalled master side fills the result buffer, then the input register, then
// o_s_tready drops; nothing is dropped
// reset clears mode, position, token start (zero) and line count (one), and empties
// the buffer; after an end-of-source request the scan state returns to those same values
// depends on tsc_pkg, tsc_scan, tsc_result_q
`timescale 1ns / 1ps
`default_nettype none

module token_scanner #(
    parameter int POS_WIDTH = 16
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_tvalid,
    output logic        o_s_tready,
    input  wire  [7:0]  i_s_tdata,   // src_byte [7:0]
    input  wire         i_s_tlast,   // end_of_source
    output logic        o_m_tvalid,
    input  wire         i_m_tready,
    output logic [47:0] o_m_tdata,   // text_start [15:0], text_length [31:16], line_number [47:32]
    output logic [4:0]  o_m_tuser,   // token_kind [4:0]
    output logic        o_m_tlast    // last_result
);
    import tsc_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_end;

    t_scan_out  scan;
    t_result    res;
    logic       q_free, adv, pop;

    assign pop        = o_m_tvalid && i_m_tready;
    assign adv        = r_in_valid && (q_free || !(scan.v0 || scan.v1));
    assign o_s_tready = !r_in_valid || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_byte <= i_s_tdata;
            r_in_end  <= i_s_tlast;
        end
    end

    tsc_scan #(
        .POS_WIDTH (POS_WIDTH)
    ) u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_byte  (r_in_byte),
        .i_end   (r_in_end),
        .o_scan  (scan)
    );

    tsc_result_q u_result_q (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (adv),
        .i_scan   (scan),
        .i_pop    (pop),
        .o_free   (q_free),
        .o_valid  (o_m_tvalid),
        .o_result (res)
    );

    assign o_m_tdata = {res.line, res.length, res.start};
    assign o_m_tuser = res.kind;
    assign o_m_tlast = res.last;

endmodule

`default_nettype wire

FILE: dv/token_scanner_tb.sv
// token_scanner_tb: self-checking bench for the token scanner
// drives source bytes on the slave stream, predicts every token record and checks the
// master stream against it; depends on tsc_pkg and token_scanner
`timescale 1ns / 1ps

module token_scanner_tb;
    import tsc_pkg::*;

    localparam logic [15:0] POS_MAX = 16'hFFFF;

    typedef struct packed {
        logic [7:0] src;
        logic       eos;
    } t_src_item;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic [7:0]  s_data = 8'h00;
    logic        s_last = 1'b0;
    logic        m_ready = 1'b0;
    logic        o_s_tready;
    logic        o_m_tvalid;
    logic [47:0] o_m_tdata;
    logic [4:0]  o_m_tuser;
    logic        o_m_tlast;

    token_scanner u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_valid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (s_data),    // src_byte [7:0]
        .i_s_tlast  (s_last),    // end_of_source
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (m_ready),
        .o_m_tdata  (o_m_tdata), // text_start [15:0], text_length [31:16], line_number [47:32]
        .o_m_tuser  (o_m_tuser), // token_kind [4:0]
        .o_m_tlast  (o_m_tlast)  // last_result
    );

    t_src_item   src_bytes[$];
    t_result     tokens_due[$];
    logic        idle_on = 1'b0;
    logic        req_taken = 1'b0;
    int          src_hold = 0;
    int          sink_hold = 0;
    int unsigned items_sent = 0;
    int unsigned sources_sent = 0;
    int unsigned tokens_checked = 0;
    int unsigned errors = 0;

    // scanner state as predicted
    t_mode       scan_md;
    logic [15:0] pos_q;
    logic [15:0] begin_q;
    logic [15:0] line_q;
    t_result     step_res[2];
    int          step_n;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("timeout at %0t", $time);
        $display("Test completed with failures");
        $finish;
    end

    function automatic logic [15:0] pos_inc(logic [15:0] p);
        return (p == POS_MAX) ? p : p + 16'd1;
    endfunction

    function automatic logic [4:0] op_kind(t_mode m);
        case (m)
            MODE_BANG:  return KIND_BANG;
            MODE_EQUAL: return KIND_EQUAL;
            MODE_LESS:  return KIND_LESS;
            default:    return KIND_GREATER;
        endcase
    endfunction

    task automatic clear_scan_state();
        scan_md = MODE_NORMAL;
        pos_q   = 16'd0;
        begin_q = 16'd0;
        line_q  = LINE_FIRST;
    endtask

    task automatic count_line();
        if (line_q != LINE_MAX) line_q = line_q + 16'd1;
    endtask

    task automatic emit_token(logic [4:0] k, logic [15:0] s, logic [15:0] l);
        step_res[step_n].kind   = k;
        step_res[step_n].start  = s;
        step_res[step_n].length = l;
        step_res[step_n].line   = line_q;
        step_res[step_n].last   = 1'b0;
        step_n++;
    endtask

    task automatic scan_plain(logic [7:0] c, logic [15:0] cur);
        case (c)
            CH_LPAREN: emit_token(KIND_LPAREN, cur, 16'd1);
            CH_RPAREN: emit_token(KIND_RPAREN, cur, 16'd1);
            CH_LBRACE: emit_token(KIND_LBRACE, cur, 16'd1);
            CH_RBRACE: emit_token(KIND_RBRACE, cur, 16'd1);
            CH_COMMA:  emit_token(KIND_COMMA, cur, 16'd1);
            CH_DOT:    emit_token(KIND_DOT, cur, 16'd1);
            CH_MINUS:  emit_token(KIND_MINUS, cur, 16'd1);
            CH_PLUS:   emit_token(KIND_PLUS, cur, 16'd1);
            CH_SEMI:   emit_token(KIND_SEMI, cur, 16'd1);
            CH_STAR:   emit_token(KIND_STAR, cur, 16'd1);
            default: begin
                begin_q = cur;
                case (c)
                    CH_BANG:    scan_md = MODE_BANG;
                    CH_EQUAL:   scan_md = MODE_EQUAL;
                    CH_LESS:    scan_md = MODE_LESS;
                    CH_GREATER: scan_md = MODE_GREATER;
                    CH_SLASH:   scan_md = MODE_SLASH;
                    CH_QUOTE:   scan_md = MODE_STRING;
                    CH_SPACE, CH_CR, CH_TAB: ;
                    CH_NL:      count_line();
                    default:    emit_token(KIND_UNEXPECTED, cur, 16'd1);
                endcase
            end
        endcase
    endtask

    task automatic predict_tokens(logic [7:0] c, logic eos);
        logic [15:0] cur;
        logic        pending_op;
        cur = pos_q;
        step_n = 0;
        pending_op = scan_md inside {MODE_BANG, MODE_EQUAL, MODE_LESS, MODE_GREATER};
        if (begin_q > cur) begin_q = cur;
        if (eos) begin
            if (pending_op) begin
                emit_token(op_kind(scan_md), begin_q, 16'd1);
            end else if (scan_md == MODE_SLASH) begin
                emit_token(KIND_SLASH, begin_q, 16'd1);
            end else if (scan_md == MODE_STRING) begin
                emit_token(KIND_UNTERMINATED, begin_q, cur - begin_q);
            end
            emit_token(KIND_EOF, cur, 16'd0);
            clear_scan_state();
        end else begin
            if (pending_op) begin
                // the two-character form follows its one-character kind
                if (c == CH_EQUAL) begin
                    emit_token(op_kind(scan_md) + 5'd1, begin_q, cur - begin_q + 16'd1);
                    scan_md = MODE_NORMAL;
                end else begin
                    emit_token(op_kind(scan_md), begin_q, 16'd1);
                    scan_md = MODE_NORMAL;
                    scan_plain(c, cur);
                end
            end else if (scan_md == MODE_SLASH) begin
                if (c == CH_SLASH) begin
                    scan_md = MODE_COMMENT;
                end else begin
                    scan_md = MODE_NORMAL;
                    emit_token(KIND_SLASH, begin_q, 16'd1);
                    scan_plain(c, cur);
                end
            end else if (scan_md == MODE_COMMENT) begin
                if (c == CH_NL) begin
                    scan_md = MODE_NORMAL;
                    scan_plain(c, cur);
                end
            end else if (scan_md == MODE_STRING) begin
                if (c == CH_QUOTE) begin
                    emit_token(KIND_STRING, pos_inc(begin_q),
                               (cur > begin_q) ? cur - begin_q - 16'd1 : 16'd0);
                    scan_md = MODE_NORMAL;
                end else if (c == CH_NL) begin
                    count_line();
                end
            end else begin
                scan_md = MODE_NORMAL;
                scan_plain(c, cur);
            end
            pos_q = pos_inc(cur);
        end
        if (step_n > 0) step_res[step_n - 1].last = 1'b1;
        for (int i = 0; i < step_n; i++) tokens_due = {tokens_due, step_res[i]};
    endtask

    // request side
    always @(negedge i_clk) begin : src_drive
        t_src_item it;
        if (!i_rst_n) begin
            s_valid <= 1'b0;
        end else if (s_valid && !req_taken) begin
        end else if (src_hold > 0) begin
            src_hold <= src_hold - 1;
            s_valid <= 1'b0;
        end else if (idle_on && $urandom_range(0, 6) == 0) begin
            src_hold <= $urandom_range(0, 3);
            s_valid <= 1'b0;
        end else if (src_bytes.size() > 0) begin
            it = src_bytes.pop_front();
            s_data <= it.src;
            s_last <= it.eos;
            s_valid <= 1'b1;
        end else begin
            s_valid <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        req_taken <= s_valid && o_s_tready;
        if (s_valid && o_s_tready) predict_tokens(s_data, s_last);
    end

    // result side
    always @(negedge i_clk) begin
        if (sink_hold > 0) begin
            sink_hold <= sink_hold - 1;
            m_ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 6) == 0) begin
            sink_hold <= $urandom_range(0, 3);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : tok_mon
        t_result got;
        t_result want;
        if (o_m_tvalid && m_ready) begin
            got.kind   = o_m_tuser;
            got.start  = o_m_tdata[15:0];
            got.length = o_m_tdata[31:16];
            got.line   = o_m_tdata[47:32];
            got.last   = o_m_tlast;
            if (tokens_due.size() == 0) begin
                errors <= errors + 1;
                $display("%0t: token with none due: kind %0d start %0d len %0d line %0d last %0b",
                         $time, got.kind, got.start, got.length, got.line, got.last);
            end else begin
                want = tokens_due.pop_front();
                tokens_checked <= tokens_checked + 1;
                if (got !== want) begin
                    errors <= errors + 1;
                    $display("%0t: mismatch exp kind %0d start %0d len %0d line %0d last %0b,",
                             $time, want.kind, want.start, want.length, want.line, want.last);
                    $display("    got kind %0d start %0d len %0d line %0d last %0b",
                             got.kind, got.start, got.length, got.line, got.last);
                end
            end
        end
    end

    task automatic push_item(logic [7:0] b, logic e);
        t_src_item it;
        it.src = b;
        it.eos = e;
        src_bytes = {src_bytes, it};
        items_sent++;
    endtask

    task automatic push_text(string s);
        for (int i = 0; i < s.len(); i++) push_item(s[i], 1'b0);
    endtask

    task automatic push_eos();
        push_item(8'($urandom_range(0, 255)), 1'b1);
        sources_sent++;
    endtask

    function automatic logic [7:0] punct_char(int i);
        case (i)
            0: return CH_LPAREN;
            1: return CH_RPAREN;
            2: return CH_LBRACE;
            3: return CH_RBRACE;
            4: return CH_COMMA;
            5: return CH_DOT;
            6: return CH_MINUS;
            7: return CH_PLUS;
            8: return CH_SEMI;
            default: return CH_STAR;
        endcase
    endfunction

    function automatic logic [7:0] op_char(int i);
        case (i)
            0: return CH_BANG;
            1: return CH_EQUAL;
            2: return CH_LESS;
            default: return CH_GREATER;
        endcase
    endfunction

    task automatic add_fragment();
        int k;
        logic [7:0] b;
        case ($urandom_range(0, 11))
            0, 1: push_item(punct_char($urandom_range(0, 9)), 1'b0);
            2, 3: begin
                push_item(op_char($urandom_range(0, 3)), 1'b0);
                if ($urandom_range(0, 1)) push_item(CH_EQUAL, 1'b0);
            end
            4: push_item(CH_SLASH, 1'b0);
            5: begin
                push_item(CH_SLASH, 1'b0);
                push_item(CH_SLASH, 1'b0);
                k = $urandom_range(0, 6);
                for (int j = 0; j < k; j++) begin
                    b = 8'($urandom_range(0, 255));
                    push_item((b == CH_NL) ? CH_SPACE : b, 1'b0);
                end
                if ($urandom_range(0, 5) != 0) push_item(CH_NL, 1'b0);
            end
            6: begin
                push_item(CH_QUOTE, 1'b0);
                k = $urandom_range(0, 8);
                for (int j = 0; j < k; j++) begin
                    b = 8'($urandom_range(0, 255));
                    push_item((b == CH_QUOTE) ? CH_NL : b, 1'b0);
                end
                if ($urandom_range(0, 7) != 0) push_item(CH_QUOTE, 1'b0);
            end
            7: begin
                case ($urandom_range(0, 2))
                    0: push_item(CH_SPACE, 1'b0);
                    1: push_item(CH_CR, 1'b0);
                    default: push_item(CH_TAB, 1'b0);
                endcase
            end
            8: push_item(CH_NL, 1'b0);
            9: push_item(8'($urandom_range(0, 255)), 1'b0);
            default: push_item(8'($urandom_range(8'h61, 8'h7A)), 1'b0);
        endcase
    endtask

    task automatic add_source();
        int nfrag;
        nfrag = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 30);
        for (int i = 0; i < nfrag; i++) add_fragment();
        push_eos();
    endtask

    task automatic wait_drained();
        while (src_bytes.size() != 0 || s_valid || tokens_due.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    initial begin : stim
        int unsigned base;
        clear_scan_state();
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;
        idle_on = 1'b1;

        // punctuation and byte extremes
        push_text("(){},.-+;*");
        push_item(8'h00, 1'b0);
        push_item(8'hFF, 1'b0);
        push_eos();
        // every operator alone and with '=', slash before another token, eof with a pending op
        push_text("===(!=!<=<>=>/x<");
        push_eos();
        // newline in a string, blanks, comment up to newline, eof inside a string
        push_text("\"a\nb\" ");
        push_item(CH_CR, 1'b0);
        push_text("\t//c\n\"q");
        push_eos();
        // eof inside a comment, empty source, eof after a lone slash
        push_text("//z");
        push_eos();
        push_eos();
        push_text("/");
        push_eos();
        wait_drained();

        base = items_sent;
        while (items_sent - base < 500) add_source();
        wait_drained();

        idle_on = 1'b0;
        base = items_sent;
        while (items_sent - base < 100) add_source();
        wait_drained();
        repeat (20) @(posedge i_clk);

        $display("%0d requests in %0d sources sent, %0d tokens checked, %0d errors",
                 items_sent, sources_sent, tokens_checked, errors);
        $display("covered all token kinds, comments, strings and eof flushes under stalls");
        if (errors == 0 && tokens_due.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

FILE: sim.f
sv/tsc_pkg.sv
sv/tsc_scan.sv
sv/tsc_result_q.sv
sv/token_scanner.sv
dv/token_scanner_tb.sv
